// File: src/cfl_pkg.sv
// Package for the CFL time-step reduction block.
// Shared widths, constants, register codes, item/config structs and FSM states.
// No dependencies.
package cfl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int DEN_W      = WORD_W + 2;
  localparam int DIV_W      = 2 * WORD_W;
  localparam int Q_W        = DIV_W - FRAC_BITS;
  localparam int ROOT_W     = DIV_W / 2;
  localparam int MIN_W      = 33;
  localparam int OUT_W      = 33;
  localparam int COURANT_W  = 17;
  localparam int EPROD_W    = COURANT_W + MIN_W;
  localparam int IDX_W      = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [MIN_W-1:0] INIT_MIN = MIN_W'(64'd100000 << FRAC_BITS);

  typedef enum logic [IDX_W-1:0] {
    REG_DIM_COUNT,
    REG_GAS_FACTOR,
    REG_SPACING_X,
    REG_SPACING_Y,
    REG_SPACING_Z,
    REG_COURANT
  } reg_index_t;

  typedef struct packed {
    logic [1:0]           dim_count;
    logic [WORD_W-1:0]    gas_factor;
    logic [WORD_W-1:0]    spacing_x;
    logic [WORD_W-1:0]    spacing_y;
    logic [WORD_W-1:0]    spacing_z;
    logic [COURANT_W-1:0] courant;
  } cfl_cfg_t;

  // classified cell as it travels from front to back
  typedef struct packed {
    logic [WORD_W-1:0]        rho;
    logic [WORD_W-1:0]        p;
    logic [2:0][WORD_W-1:0]   speed;
    logic                     last;
    logic                     rho_zero;
  } cfl_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_QSTART,
    S_QDIV,
    S_SQRT,
    S_TSTART,
    S_TDIV,
    S_FOLD,
    S_EMIT,
    S_OUT
  } cfl_state_t;

endpackage

// File: src/cfl_front.sv
// Front end: takes in cell transactions, forms |v| per axis and flags zero density.
// Depends on cfl_pkg.
module cfl_front (
  input  logic                          push,
  input  logic                          fifo_full,
  input  logic [cfl_pkg::WORD_W-1:0]    density,
  input  logic [cfl_pkg::WORD_W-1:0]    pressure,
  input  logic signed [cfl_pkg::WORD_W-1:0] vel_x,
  input  logic signed [cfl_pkg::WORD_W-1:0] vel_y,
  input  logic signed [cfl_pkg::WORD_W-1:0] vel_z,
  input  logic                          last_cell,
  output logic                          fifo_we,
  output cfl_pkg::cfl_item_t            fifo_item
);

  function automatic logic [cfl_pkg::WORD_W-1:0] mag(input logic [cfl_pkg::WORD_W-1:0] v);
    // -2^31 maps to 2^31, which still fits unsigned
    mag = v[cfl_pkg::WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    fifo_we            = push && !fifo_full;
    fifo_item.rho      = density;
    fifo_item.p        = pressure;
    fifo_item.speed[0] = mag(vel_x);
    fifo_item.speed[1] = mag(vel_y);
    fifo_item.speed[2] = mag(vel_z);
    fifo_item.last     = last_cell;
    fifo_item.rho_zero = (density == '0);
  end

endmodule

// File: src/cfl_fifo.sv
// Short queue of classified cells between front and back.
// Depends on cfl_pkg.
module cfl_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  cfl_pkg::cfl_item_t wr_item,
  input  logic               re,
  output cfl_pkg::cfl_item_t rd_item,
  output logic               full,
  output logic               empty
);

  cfl_pkg::cfl_item_t              mem [cfl_pkg::FIFO_DEPTH];
  logic [cfl_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [cfl_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [cfl_pkg::FIFO_PTR_W:0]    count;

  assign full    = (count == (cfl_pkg::FIFO_PTR_W+1)'(cfl_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (we) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (re) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (cfl_pkg::FIFO_PTR_W+1)'(we) - (cfl_pkg::FIFO_PTR_W+1)'(re);
    end
  end

endmodule

// File: src/cfl_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on cfl_pkg.
module cfl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cfl_pkg::DIV_W-1:0]   dividend,
  input  logic [cfl_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [cfl_pkg::DIV_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(cfl_pkg::DIV_W);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [cfl_pkg::DEN_W-1:0]   rem;
  logic [cfl_pkg::DEN_W-1:0]   dsr;
  logic [cfl_pkg::DIV_W-1:0]   dq;
  logic [cfl_pkg::DEN_W:0]     rem_sh;
  logic                        fits;

  assign rem_sh   = {rem, dq[cfl_pkg::DIV_W-1]};
  assign fits     = (rem_sh >= {1'b0, dsr});
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dq  <= dividend;
      cnt <= CNT_W'(cfl_pkg::DIV_W - 1);
    end else if (busy) begin
      rem <= fits ? cfl_pkg::DEN_W'(rem_sh - {1'b0, dsr}) : cfl_pkg::DEN_W'(rem_sh);
      dq  <= {dq[cfl_pkg::DIV_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

// File: src/cfl_back.sv
// Back end: sound speed, per-axis crossing times, running minimum and result register.
// Depends on cfl_pkg and cfl_div.
module cfl_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cfl_pkg::cfl_cfg_t                      cfg,
  input  logic                                   fifo_empty,
  input  cfl_pkg::cfl_item_t                     fifo_item,
  output logic                                   fifo_pop,
  input  logic                                   pop,
  output logic                                   out_valid,
  output logic [cfl_pkg::OUT_W-1:0]              out_ts,
  output logic                                   out_bad
);

  cfl_pkg::cfl_state_t state, state_next;

  cfl_pkg::cfl_item_t              item;
  logic                            skip;
  logic [cfl_pkg::DIV_W-1:0]       prod;
  logic [cfl_pkg::DIV_W-1:0]       sq_x;
  logic [cfl_pkg::ROOT_W+3:0]      sq_rem;
  logic [cfl_pkg::ROOT_W-1:0]      root;
  logic [$clog2(cfl_pkg::ROOT_W)-1:0] step;
  logic [1:0]                      dim;
  logic [1:0]                      last_dim;
  logic [cfl_pkg::MIN_W-1:0]       cell_min;
  logic [cfl_pkg::MIN_W-1:0]       running_min;
  logic                            bad_flag;
  logic [cfl_pkg::EPROD_W-1:0]     eprod;

  logic                            div_start;
  logic                            div_done;
  logic [cfl_pkg::DIV_W-1:0]       div_dividend;
  logic [cfl_pkg::DEN_W-1:0]       div_divisor;
  logic [cfl_pkg::DIV_W-1:0]       div_quot;

  logic [cfl_pkg::DEN_W-1:0]       den;
  logic [cfl_pkg::WORD_W-1:0]      spacing;
  logic [cfl_pkg::ROOT_W+3:0]      rem_sh;
  logic [cfl_pkg::ROOT_W+3:0]      trial;
  logic                            sq_fits;
  logic [cfl_pkg::Q_W-1:0]         q_sat;
  logic [cfl_pkg::MIN_W-1:0]       t_clip;
  logic [cfl_pkg::OUT_W:0]         ts_wide;
  logic                            out_free;

  cfl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    case (cfg.dim_count)
      2'd1:    last_dim = 2'd0;
      2'd2:    last_dim = 2'd1;
      default: last_dim = 2'd2;
    endcase
    case (dim)
      2'd0:    spacing = cfg.spacing_x;
      2'd1:    spacing = cfg.spacing_y;
      default: spacing = cfg.spacing_z;
    endcase
    den     = {2'b00, item.speed[dim]} + {2'b00, root};
    rem_sh  = {sq_rem[cfl_pkg::ROOT_W+1:0], sq_x[cfl_pkg::DIV_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    sq_fits = (rem_sh >= trial);
    // saturate K*p/rho so the shifted sqrt operand stays within 64 bits
    q_sat   = (div_quot[cfl_pkg::DIV_W-1:cfl_pkg::Q_W] != '0) ? '1 : div_quot[cfl_pkg::Q_W-1:0];
    t_clip  = (div_quot[cfl_pkg::DIV_W-1:cfl_pkg::MIN_W] != '0) ? '1 : div_quot[cfl_pkg::MIN_W-1:0];
    ts_wide = eprod[cfl_pkg::EPROD_W-1:cfl_pkg::FRAC_BITS];
    out_free = !out_valid || pop;
    div_dividend = (state == cfl_pkg::S_QSTART) ? prod
                 : (cfl_pkg::DIV_W'(spacing) << cfl_pkg::FRAC_BITS);
    div_divisor  = (state == cfl_pkg::S_QSTART) ? {2'b00, item.rho} : den;
  end

  always_comb begin
    state_next = state;
    fifo_pop   = 1'b0;
    div_start  = 1'b0;
    case (state)
      cfl_pkg::S_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop   = 1'b1;
          state_next = fifo_item.rho_zero ? cfl_pkg::S_FOLD : cfl_pkg::S_MUL;
        end
      end
      cfl_pkg::S_MUL:    state_next = cfl_pkg::S_QSTART;
      cfl_pkg::S_QSTART: begin
        div_start  = 1'b1;
        state_next = cfl_pkg::S_QDIV;
      end
      cfl_pkg::S_QDIV: begin
        if (div_done) begin
          state_next = cfl_pkg::S_SQRT;
        end
      end
      cfl_pkg::S_SQRT: begin
        if (step == '1) begin
          state_next = cfl_pkg::S_TSTART;
        end
      end
      cfl_pkg::S_TSTART: begin
        if (den == '0) begin
          state_next = (dim == last_dim) ? cfl_pkg::S_FOLD : cfl_pkg::S_TSTART;
        end else begin
          div_start  = 1'b1;
          state_next = cfl_pkg::S_TDIV;
        end
      end
      cfl_pkg::S_TDIV: begin
        if (div_done) begin
          state_next = (dim == last_dim) ? cfl_pkg::S_FOLD : cfl_pkg::S_TSTART;
        end
      end
      cfl_pkg::S_FOLD:   state_next = item.last ? cfl_pkg::S_EMIT : cfl_pkg::S_IDLE;
      cfl_pkg::S_EMIT:   state_next = cfl_pkg::S_OUT;
      cfl_pkg::S_OUT: begin
        if (out_free) begin
          state_next = cfl_pkg::S_IDLE;
        end
      end
      default:           state_next = cfl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      cfl_pkg::S_IDLE: begin
        item     <= fifo_item;
        cell_min <= '1;
        dim      <= 2'd0;
      end
      cfl_pkg::S_MUL: begin
        prod <= cfl_pkg::DIV_W'(item.p) * cfl_pkg::DIV_W'(cfg.gas_factor);
      end
      cfl_pkg::S_QDIV: begin
        sq_x   <= {q_sat, cfl_pkg::FRAC_BITS'(0)};
        sq_rem <= '0;
        root   <= '0;
        step   <= '0;
      end
      cfl_pkg::S_SQRT: begin
        sq_x   <= {sq_x[cfl_pkg::DIV_W-3:0], 2'b00};
        sq_rem <= sq_fits ? (rem_sh - trial) : rem_sh;
        root   <= {root[cfl_pkg::ROOT_W-2:0], sq_fits};
        step   <= step + 1'b1;
      end
      cfl_pkg::S_TSTART: begin
        if (den == '0) begin
          dim <= dim + 1'b1;
        end
      end
      cfl_pkg::S_TDIV: begin
        if (div_done) begin
          dim <= dim + 1'b1;
          if (t_clip < cell_min) begin
            cell_min <= t_clip;
          end
        end
      end
      cfl_pkg::S_EMIT: begin
        eprod <= cfl_pkg::EPROD_W'(cfg.courant) * cfl_pkg::EPROD_W'(running_min);
      end
      default: begin
      end
    endcase
  end

  // skip mark, running state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      skip        <= 1'b0;
      running_min <= cfl_pkg::INIT_MIN;
      bad_flag    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == cfl_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        cfl_pkg::S_IDLE: begin
          skip <= fifo_item.rho_zero;
        end
        cfl_pkg::S_TSTART: begin
          if (den == '0) begin
            skip <= 1'b1;
          end
        end
        cfl_pkg::S_FOLD: begin
          if (skip) begin
            bad_flag <= 1'b1;
          end else if (cell_min < running_min) begin
            running_min <= cell_min;
          end
        end
        cfl_pkg::S_OUT: begin
          if (out_free) begin
            out_ts      <= ts_wide[cfl_pkg::OUT_W] ? '1 : ts_wide[cfl_pkg::OUT_W-1:0];
            out_bad     <= bad_flag;
            running_min <= cfl_pkg::INIT_MIN;
            bad_flag    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_min_bounded: assert property (@(posedge clk) disable iff (rst)
      running_min <= cfl_pkg::INIT_MIN)
    else $error("running minimum above its start value");
  a_skip_flags: assert property (@(posedge clk) disable iff (rst)
      (state == cfl_pkg::S_FOLD && skip) |=> bad_flag)
    else $error("skipped cell not flagged");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
      fifo_pop |-> (state == cfl_pkg::S_IDLE && !fifo_empty))
    else $error("queue read outside idle");
  a_sweep_restart: assert property (@(posedge clk) disable iff (rst)
      (state == cfl_pkg::S_OUT && out_free) |=>
      (running_min == cfl_pkg::INIT_MIN && !bad_flag && out_valid))
    else $error("sweep state not restarted after result");

endmodule

// File: src/cfl_timestep_min_reduce.sv
// Top level of the CFL time-step reduction: config registers, front, queue, back.
// Depends on cfl_pkg, cfl_front, cfl_fifo, cfl_back.
//
//  channel   handshake            payload
//  cells     push / full          density pressure vel_x vel_y vel_z last_cell
//  result    empty / pop          time_step bad_cell_seen
//  config    wr_en                wr_index wr_data
//
// A cell in the back end runs the product, a K*p/rho division, the 32-step
// square root and one crossing-time division per active dimension, every division
// on the shared bit-serial divider. After the last cell, S_EMIT and S_OUT form the result.
// A four-entry queue lets cells be taken while the back end is busy.
// rst is synchronous; it clears the queue, minimum, flag and config to defaults.
module cfl_timestep_min_reduce (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [cfl_pkg::WORD_W-1:0]           density,
  input  logic [cfl_pkg::WORD_W-1:0]           pressure,
  input  logic signed [cfl_pkg::WORD_W-1:0]    vel_x,
  input  logic signed [cfl_pkg::WORD_W-1:0]    vel_y,
  input  logic signed [cfl_pkg::WORD_W-1:0]    vel_z,
  input  logic                                 last_cell,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [cfl_pkg::OUT_W-1:0]            time_step,
  output logic                                 bad_cell_seen,
  input  logic                                 wr_en,
  input  logic [cfl_pkg::IDX_W-1:0]            wr_index,
  input  logic [cfl_pkg::WORD_W-1:0]           wr_data
);

  cfl_pkg::cfl_cfg_t  cfg;
  cfl_pkg::cfl_item_t fe_item;
  cfl_pkg::cfl_item_t q_item;
  logic               fe_we;
  logic               q_empty;
  logic               q_pop;
  logic               out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_count  <= 2'd1;
      cfg.gas_factor <= cfl_pkg::WORD_W'(1) << cfl_pkg::FRAC_BITS;
      cfg.spacing_x  <= cfl_pkg::WORD_W'(1) << cfl_pkg::FRAC_BITS;
      cfg.spacing_y  <= cfl_pkg::WORD_W'(1) << cfl_pkg::FRAC_BITS;
      cfg.spacing_z  <= cfl_pkg::WORD_W'(1) << cfl_pkg::FRAC_BITS;
      cfg.courant    <= cfl_pkg::COURANT_W'(1) << (cfl_pkg::FRAC_BITS - 1);
    end else if (wr_en) begin
      case (cfl_pkg::reg_index_t'(wr_index))
        cfl_pkg::REG_DIM_COUNT:  cfg.dim_count  <= wr_data[1:0];
        cfl_pkg::REG_GAS_FACTOR: cfg.gas_factor <= wr_data;
        cfl_pkg::REG_SPACING_X:  cfg.spacing_x  <= wr_data;
        cfl_pkg::REG_SPACING_Y:  cfg.spacing_y  <= wr_data;
        cfl_pkg::REG_SPACING_Z:  cfg.spacing_z  <= wr_data;
        cfl_pkg::REG_COURANT:    cfg.courant    <= wr_data[cfl_pkg::COURANT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cfl_front u_front (
    .push      (push),
    .fifo_full (full),
    .density   (density),
    .pressure  (pressure),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .last_cell (last_cell),
    .fifo_we   (fe_we),
    .fifo_item (fe_item)
  );

  cfl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .we      (fe_we),
    .wr_item (fe_item),
    .re      (q_pop),
    .rd_item (q_item),
    .full    (full),
    .empty   (q_empty)
  );

  cfl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_empty (q_empty),
    .fifo_item  (q_item),
    .fifo_pop   (q_pop),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ts     (time_step),
    .out_bad    (bad_cell_seen)
  );

  assign empty = !out_valid;

endmodule
